// File: rtl/lr_pkg.sv
// line rasterizer package: shared constants and item mode codes
// no dependencies; used by lr_front, lr_queue, lr_back and the top level

package lr_pkg;

    // default coordinate width and depth of the queue between front and back
    localparam int COORD_WIDTH_DEFAULT = 10;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // mode field of an input transaction
    typedef enum logic
    {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } mode_t;

    // width of one queued command for a given coordinate width
    function automatic int cmd_width(input int coord_width);
        return 6 * coord_width + 12;
    endfunction

endpackage

// File: rtl/lr_in_if.sv
// input channel of the line rasterizer: valid/ready plus load/step payload
// depends on nothing; width follows COORD_WIDTH

interface lr_in_if #(
    parameter int COORD_WIDTH = 10
);
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [COORD_WIDTH-1:0] x_start;
    logic [COORD_WIDTH-1:0] y_start;
    logic [COORD_WIDTH-1:0] x_end;
    logic [COORD_WIDTH-1:0] y_end;

    modport source
    (
        output valid, mode, x_start, y_start, x_end, y_end,
        input  ready
    );

    modport sink
    (
        input  valid, mode, x_start, y_start, x_end, y_end,
        output ready
    );
endinterface

// File: rtl/lr_out_if.sv
// output channel of the line rasterizer: valid/ready plus pixel payload
// depends on nothing; width follows COORD_WIDTH

interface lr_out_if #(
    parameter int COORD_WIDTH = 10
);
    logic                   valid;
    logic                   ready;
    logic                   pixel_valid;
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;
    logic                   last_pixel;

    modport source
    (
        output valid, pixel_valid, pixel_x, pixel_y, last_pixel,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_valid, pixel_x, pixel_y, last_pixel,
        output ready
    );
endinterface

// File: rtl/lr_front.sv
// front end: accepts input transactions and turns loads into line setup commands
// depends on lr_pkg and lr_in_if

module lr_front #(
    parameter int COORD_WIDTH = lr_pkg::COORD_WIDTH_DEFAULT,
    parameter int CMD_WIDTH   = lr_pkg::cmd_width(lr_pkg::COORD_WIDTH_DEFAULT)
)
(
    lr_in_if.sink                cmd,
    output logic                 push_valid,
    input  logic                 push_ready,
    output logic [CMD_WIDTH-1:0] push_data
);
    localparam int W = COORD_WIDTH;

    typedef struct packed
    {
        logic                load;
        logic [W-1:0]        first_x;
        logic [W-1:0]        first_y;
        logic [W-1:0]        stop;
        logic signed [W+2:0] decision;
        logic [W+1:0]        straight;
        logic signed [W+2:0] diagonal;
        logic                steep;
        logic                minor_down;
        logic                first_last;
    } cmd_t;

    cmd_t         setup;
    logic [W-1:0] adx;
    logic [W-1:0] ady;
    logic [W-1:0] maj;
    logic [W-1:0] mnr;
    logic         steep;
    logic         swap;

    assign cmd.ready  = push_ready;
    assign push_valid = cmd.valid;

    always_comb
    begin
        adx   = (cmd.x_end >= cmd.x_start) ? (cmd.x_end - cmd.x_start)
                                           : (cmd.x_start - cmd.x_end);
        ady   = (cmd.y_end >= cmd.y_start) ? (cmd.y_end - cmd.y_start)
                                           : (cmd.y_start - cmd.y_end);
        steep = (ady >= adx);
        maj   = steep ? ady : adx;
        mnr   = steep ? adx : ady;
        // draw from the endpoint lower on the major axis
        swap  = steep ? (cmd.y_start > cmd.y_end) : (cmd.x_start > cmd.x_end);

        setup.load       = (cmd.mode == lr_pkg::MODE_LOAD);
        setup.first_x    = swap ? cmd.x_end : cmd.x_start;
        setup.first_y    = swap ? cmd.y_end : cmd.y_start;
        setup.stop       = steep ? (swap ? cmd.y_start : cmd.y_end)
                                 : (swap ? cmd.x_start : cmd.x_end);
        setup.straight   = {1'b0, mnr, 1'b0};
        setup.decision   = $signed({2'b00, mnr, 1'b0}) - $signed({3'b000, maj});
        setup.diagonal   = $signed({2'b00, mnr, 1'b0}) - $signed({2'b00, maj, 1'b0});
        setup.steep      = steep;
        setup.minor_down = (cmd.x_end < cmd.x_start) != (cmd.y_end < cmd.y_start);
        // zero major span means a single pixel on the major axis
        setup.first_last = (maj == '0);
    end

    assign push_data = setup;
endmodule

// File: rtl/lr_queue.sv
// small fifo between the front end and the pixel stepper
// depends on lr_pkg for its default depth

module lr_queue #(
    parameter int DATA_WIDTH = lr_pkg::cmd_width(lr_pkg::COORD_WIDTH_DEFAULT),
    parameter int DEPTH      = lr_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output logic [DATA_WIDTH-1:0] pop_data
);
    // pointers wrap back to zero after the last entry, so any depth works
    localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_WIDTH-1:0]  wr_ptr_reg;
    logic [PTR_WIDTH-1:0]  wr_ptr_next;
    logic [PTR_WIDTH-1:0]  rd_ptr_reg;
    logic [PTR_WIDTH-1:0]  rd_ptr_next;
    logic [CNT_WIDTH-1:0]  count_reg;
    logic [CNT_WIDTH-1:0]  count_next;
    logic                  push;
    logic                  pop;

    assign push_ready = (count_reg != CNT_WIDTH'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_WIDTH'(DEPTH - 1)) ? '0
                                                                 : PTR_WIDTH'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_WIDTH'(DEPTH - 1)) ? '0
                                                                 : PTR_WIDTH'(rd_ptr_reg + 1'b1);
        end
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CNT_WIDTH'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_WIDTH'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// File: rtl/lr_back.sv
// back end: holds the line state, returns one result per command, registers output
// depends on lr_pkg and lr_out_if

module lr_back #(
    parameter int COORD_WIDTH = lr_pkg::COORD_WIDTH_DEFAULT,
    parameter int CMD_WIDTH   = lr_pkg::cmd_width(lr_pkg::COORD_WIDTH_DEFAULT)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  logic [CMD_WIDTH-1:0] pop_data,
    lr_out_if.source             pixel
);
    localparam int W = COORD_WIDTH;

    typedef struct packed
    {
        logic                load;
        logic [W-1:0]        first_x;
        logic [W-1:0]        first_y;
        logic [W-1:0]        stop;
        logic signed [W+2:0] decision;
        logic [W+1:0]        straight;
        logic signed [W+2:0] diagonal;
        logic                steep;
        logic                minor_down;
        logic                first_last;
    } cmd_t;

    cmd_t                cmd_word;
    logic                fire;

    logic                busy_reg,       busy_next;
    logic [W-1:0]        cur_x_reg,      cur_x_next;
    logic [W-1:0]        cur_y_reg,      cur_y_next;
    logic [W-1:0]        stop_reg,       stop_next;
    logic signed [W+2:0] decision_reg,   decision_next;
    logic [W+1:0]        straight_reg,   straight_next;
    logic signed [W+2:0] diagonal_reg,   diagonal_next;
    logic                steep_reg,      steep_next;
    logic                minor_down_reg, minor_down_next;

    logic                out_valid_reg,  out_valid_next;
    logic                pix_valid_reg,  pix_valid_next;
    logic [W-1:0]        pix_x_reg,      pix_x_next;
    logic [W-1:0]        pix_y_reg,      pix_y_next;
    logic                pix_last_reg,   pix_last_next;

    logic [W-1:0]        step_x;
    logic [W-1:0]        step_y;
    logic signed [W+2:0] step_decision;
    logic                step_last;

    assign cmd_word  = pop_data;
    assign pop_ready = !out_valid_reg || pixel.ready;
    assign fire      = pop_valid && pop_ready;

    // one bresenham step from the held state
    always_comb
    begin
        step_x        = cur_x_reg;
        step_y        = cur_y_reg;
        step_decision = decision_reg + $signed({1'b0, straight_reg});
        if (steep_reg)
        begin
            step_y = W'(cur_y_reg + 1'b1);
        end
        else
        begin
            step_x = W'(cur_x_reg + 1'b1);
        end
        if (!decision_reg[W+2])
        begin
            step_decision = decision_reg + diagonal_reg;
            if (steep_reg)
            begin
                step_x = minor_down_reg ? W'(cur_x_reg - 1'b1) : W'(cur_x_reg + 1'b1);
            end
            else
            begin
                step_y = minor_down_reg ? W'(cur_y_reg - 1'b1) : W'(cur_y_reg + 1'b1);
            end
        end
        step_last = ((steep_reg ? step_y : step_x) == stop_reg);
    end

    always_comb
    begin
        busy_next       = busy_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        stop_next       = stop_reg;
        decision_next   = decision_reg;
        straight_next   = straight_reg;
        diagonal_next   = diagonal_reg;
        steep_next      = steep_reg;
        minor_down_next = minor_down_reg;

        out_valid_next  = out_valid_reg && !pixel.ready;
        pix_valid_next  = pix_valid_reg;
        pix_x_next      = pix_x_reg;
        pix_y_next      = pix_y_reg;
        pix_last_next   = pix_last_reg;

        if (fire)
        begin
            out_valid_next = 1'b1;
            if (cmd_word.load)
            begin
                busy_next       = !cmd_word.first_last;
                cur_x_next      = cmd_word.first_x;
                cur_y_next      = cmd_word.first_y;
                stop_next       = cmd_word.stop;
                decision_next   = cmd_word.decision;
                straight_next   = cmd_word.straight;
                diagonal_next   = cmd_word.diagonal;
                steep_next      = cmd_word.steep;
                minor_down_next = cmd_word.minor_down;
                pix_valid_next  = 1'b1;
                pix_x_next      = cmd_word.first_x;
                pix_y_next      = cmd_word.first_y;
                pix_last_next   = cmd_word.first_last;
            end
            else if (busy_reg)
            begin
                busy_next      = !step_last;
                cur_x_next     = step_x;
                cur_y_next     = step_y;
                decision_next  = step_decision;
                pix_valid_next = 1'b1;
                pix_x_next     = step_x;
                pix_y_next     = step_y;
                pix_last_next  = step_last;
            end
            else
            begin
                // step with no line in progress
                pix_valid_next = 1'b0;
                pix_x_next     = '0;
                pix_y_next     = '0;
                pix_last_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            stop_reg       <= '0;
            decision_reg   <= '0;
            straight_reg   <= '0;
            diagonal_reg   <= '0;
            steep_reg      <= 1'b0;
            minor_down_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            stop_reg       <= stop_next;
            decision_reg   <= decision_next;
            straight_reg   <= straight_next;
            diagonal_reg   <= diagonal_next;
            steep_reg      <= steep_next;
            minor_down_reg <= minor_down_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_valid_reg <= pix_valid_next;
        pix_x_reg     <= pix_x_next;
        pix_y_reg     <= pix_y_next;
        pix_last_reg  <= pix_last_next;
    end

    assign pixel.valid       = out_valid_reg;
    assign pixel.pixel_valid = pix_valid_reg;
    assign pixel.pixel_x     = pix_x_reg;
    assign pixel.pixel_y     = pix_y_reg;
    assign pixel.last_pixel  = pix_last_reg;
endmodule

// File: rtl/line_rasterizer.sv
// line rasterizer top level: front end, command queue and pixel stepper
// depends on lr_pkg, lr_in_if, lr_out_if, lr_front, lr_queue, lr_back
//
// usage
//   cmd carries one transaction per item: mode load (endpoints given) or step.
//   pixel carries exactly one result transaction per cmd transaction, in order.
//   a load returns the first pixel of the line, each step the next pixel;
//   last_pixel marks the final endpoint, and a step with no line in progress
//   returns pixel_valid low with zero coordinates.
//   a load while a line is in progress abandons that line.
// timing
//   a result is registered after the queue. while pixel.ready is high and
//   QUEUE_DEPTH exceeds one, one transaction per cycle is sustained: the
//   stepper only adds and compares per pixel; load setup is in the front end.
// reset and stall
//   rst_n clears the queue, the output valid flag and the line state (idle).
//   when pixel.ready is low the output register holds its result, the queue
//   fills behind it, and cmd.ready drops once the queue is full.

module line_rasterizer #(
    parameter int COORD_WIDTH = lr_pkg::COORD_WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    lr_in_if.sink    cmd,
    lr_out_if.source pixel
);
    localparam int CMD_WIDTH = lr_pkg::cmd_width(COORD_WIDTH);

    // front end to queue
    logic                 push_valid;
    logic                 push_ready;
    logic [CMD_WIDTH-1:0] push_data;

    // queue to stepper
    logic                 pop_valid;
    logic                 pop_ready;
    logic [CMD_WIDTH-1:0] pop_data;

    // classify each transaction and precompute line setup for loads
    lr_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .CMD_WIDTH   (CMD_WIDTH)
    ) u_front
    (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decouples acceptance from the stepper and output stalls
    lr_queue #(
        .DATA_WIDTH (CMD_WIDTH),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // holds the line state and produces one registered result per command
    lr_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .CMD_WIDTH   (CMD_WIDTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .pixel     (pixel)
    );
endmodule
